### rtl/pcd_pkg.sv
// Shared types, constants and helper functions for the percent decoder.
// No dependencies; the front, queue, back and top files import this package.
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    // Width of the per-string kept-byte counter.
    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int WIDE_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic REG_PLUS_AS_SPACE = 1'b0;
    localparam logic REG_MAX_OUT_BYTES = 1'b1;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One classified source byte: up to three candidate output bytes.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            t = c - CH_ZERO;
        end else begin
            // fold to lower case, then 'a'..'f' minus 'W' gives 10..15
            t = (c | 8'h20) - CH_W;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/pcd_if.sv
// Stream channel interfaces of the percent decoder: source bytes in, results out.
// Depends on nothing but the standard valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface pcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pcd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        out_last;
    logic        truncated;
    logic [15:0] out_count;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    output truncated, output out_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    input truncated, input out_count, output ready);
endinterface

`default_nettype wire

### rtl/pcd_front.sv
// Front end: accepts source bytes, tracks the escape state and turns each byte
// into a command of zero to three candidate bytes. Uses pcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcd_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         plus_as_space,
    output pcd_pkg::cmd_t     cmd,
    output logic              push
);
    import pcd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // next escape state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (is_hex(in_byte))
                    begin
                        phase_next = PH_DIGIT;
                        held_next  = in_byte;
                    end
                    else
                    begin
                        phase_next = (in_byte == CH_PCT) ? PH_PCT : PH_NONE;
                    end
                end
                PH_DIGIT:
                begin
                    if (is_hex(in_byte))
                        phase_next = PH_NONE;
                    else
                        phase_next = (in_byte == CH_PCT) ? PH_PCT : PH_NONE;
                end
                default:
                begin
                    phase_next = (in_byte == CH_PCT) ? PH_PCT : PH_NONE;
                end
            endcase
            if (in_last)
            begin
                phase_next = PH_NONE;
                held_next  = 8'h00;
            end
        end
    end

    // candidate bytes for this source byte
    always_comb
    begin
        logic [2:0][7:0] b;
        logic [1:0]      n;
        phase_t          mid;
        logic            fresh_has;
        logic [7:0]      fresh_byte;

        b          = '0;
        n          = 2'd0;
        mid        = PH_NONE;
        fresh_has  = (in_byte != CH_PCT);
        fresh_byte = (plus_as_space && (in_byte == CH_PLUS)) ? CH_SPACE : in_byte;

        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    mid = PH_DIGIT;
                end
                else
                begin
                    b[n] = CH_PCT;
                    n    = n + 2'd1;
                    if (fresh_has)
                    begin
                        b[n] = fresh_byte;
                        n    = n + 2'd1;
                    end
                    else
                    begin
                        mid = PH_PCT;
                    end
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(in_byte))
                begin
                    b[n] = {hex_val(held_reg), hex_val(in_byte)};
                    n    = n + 2'd1;
                end
                else
                begin
                    b[n] = CH_PCT;
                    n    = n + 2'd1;
                    b[n] = held_reg;
                    n    = n + 2'd1;
                    if (fresh_has)
                    begin
                        b[n] = fresh_byte;
                        n    = n + 2'd1;
                    end
                    else
                    begin
                        mid = PH_PCT;
                    end
                end
            end
            default:
            begin
                if (fresh_has)
                begin
                    b[n] = fresh_byte;
                    n    = n + 2'd1;
                end
                else
                begin
                    mid = PH_PCT;
                end
            end
        endcase

        // end of string flushes a held escape literally
        if (in_last)
        begin
            if (mid == PH_PCT)
            begin
                b[n] = CH_PCT;
                n    = n + 2'd1;
            end
            else if (mid == PH_DIGIT)
            begin
                b[n] = CH_PCT;
                n    = n + 2'd1;
                b[n] = in_byte;
                n    = n + 2'd1;
            end
        end

        cmd.bytes = b;
        cmd.cnt   = n;
        cmd.last  = in_last;
        push      = accept && ((n != 2'd0) || in_last);
    end

endmodule

`default_nettype wire

### rtl/pcd_queue.sv
// Short command queue between the front and back ends of the percent decoder.
// Register based, first word visible at the head. Uses pcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pcd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output pcd_pkg::cmd_t      head,
    output logic               empty
);
    import pcd_pkg::*;

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   fill_reg, fill_next;

    localparam logic [QPTR_BITS:0] FILL_FULL = (QPTR_BITS+1)'(QUEUE_DEPTH);

    assign full  = (fill_reg == FILL_FULL);
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        logic do_push;
        logic do_pop;
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

### rtl/pcd_back.sv
// Back end: walks the candidate bytes of each command, applies the output
// limit, and drives the registered result channel. Uses pcd_pkg and pcd_if.
`timescale 1ns / 1ps
`default_nettype none

module pcd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pcd_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    input  wire logic [15:0]   max_out_bytes,
    pcd_out_if.source          out_ch
);
    import pcd_pkg::*;

    logic [1:0]            idx_reg, idx_next;
    logic [COUNT_BITS-1:0] kept_reg, kept_next;
    logic                  ovf_reg, ovf_next;

    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        obv_reg, obv_next;
    logic        olast_reg, olast_next;
    logic        otrunc_reg, otrunc_next;
    logic [15:0] ocnt_reg, ocnt_next;

    logic [WIDE_BITS-1:0] kept_w, kept1_w, max_w, limit_w;

    assign kept_w  = WIDE_BITS'(kept_reg);
    assign kept1_w = WIDE_BITS'(kept_reg + 1'b1);
    assign max_w   = WIDE_BITS'(max_out_bytes);
    assign limit_w = (max_w > WIDE_BITS'(COUNT_MAX)) ? WIDE_BITS'(COUNT_MAX) : max_w;

    always_comb
    begin
        logic       adv;
        logic       can_keep;
        logic       last_cand;
        logic       emit;

        idx_next    = idx_reg;
        kept_next   = kept_reg;
        ovf_next    = ovf_reg;
        ob_next     = ob_reg;
        obv_next    = obv_reg;
        olast_next  = olast_reg;
        otrunc_next = otrunc_reg;
        ocnt_next   = ocnt_reg;
        pop         = 1'b0;
        emit        = 1'b0;

        adv       = !empty && (!ov_reg || out_ch.ready);
        can_keep  = !ovf_reg && (kept_w < limit_w);
        last_cand = (idx_reg == (head.cnt - 2'd1));

        if (adv)
        begin
            if (head.cnt == 2'd0)
            begin
                // status-only end of string
                emit        = 1'b1;
                ob_next     = 8'h00;
                obv_next    = 1'b0;
                olast_next  = 1'b1;
                otrunc_next = ovf_reg;
                ocnt_next   = kept_w[15:0];
                kept_next   = '0;
                ovf_next    = 1'b0;
                idx_next    = 2'd0;
                pop         = 1'b1;
            end
            else if (can_keep)
            begin
                emit        = 1'b1;
                ob_next     = head.bytes[idx_reg];
                obv_next    = 1'b1;
                ocnt_next   = kept1_w[15:0];
                olast_next  = 1'b0;
                otrunc_next = 1'b0;
                kept_next   = kept_reg + 1'b1;
                if (head.last && (last_cand || (kept1_w >= limit_w)))
                begin
                    // final kept byte; any later candidates are dropped
                    olast_next  = 1'b1;
                    otrunc_next = !last_cand;
                    kept_next   = '0;
                    ovf_next    = 1'b0;
                    idx_next    = 2'd0;
                    pop         = 1'b1;
                end
                else if (last_cand)
                begin
                    idx_next = 2'd0;
                    pop      = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            else
            begin
                // limit hit: the rest of this command is dropped at once
                idx_next = 2'd0;
                pop      = 1'b1;
                ovf_next = 1'b1;
                if (head.last)
                begin
                    emit        = 1'b1;
                    ob_next     = 8'h00;
                    obv_next    = 1'b0;
                    olast_next  = 1'b1;
                    otrunc_next = 1'b1;
                    ocnt_next   = kept_w[15:0];
                    kept_next   = '0;
                    ovf_next    = 1'b0;
                end
            end
        end

        if (emit)
            ov_next = 1'b1;
        else if (out_ch.ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            kept_reg <= '0;
            ovf_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            kept_reg <= kept_next;
            ovf_reg  <= ovf_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg     <= ob_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
        otrunc_reg <= otrunc_next;
        ocnt_reg   <= ocnt_next;
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.out_byte   = ob_reg;
    assign out_ch.byte_valid = obv_reg;
    assign out_ch.out_last   = olast_reg;
    assign out_ch.truncated  = otrunc_reg;
    assign out_ch.out_count  = ocnt_reg;

endmodule

`default_nettype wire

### rtl/percent_decoder_top.sv
// Percent decoder top level: configuration registers, front end, command
// queue and back end. Uses pcd_pkg, pcd_if, pcd_front, pcd_queue, pcd_back.
//
// Usage:
//   in_ch takes one source byte per request, in_last on the final byte of a
//   string (strings hold at least one byte, no terminating NUL). out_ch gives
//   decoded bytes with a running kept count; the final result of a string has
//   out_last set and truncated telling whether the output limit dropped bytes.
//   A string that ends with no decoded byte gets one status result with
//   byte_valid low.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 plus_as_space, 1 max_out_bytes); write only while the block is idle.
//   A result passes through the command queue and then the output register once
//   its source byte is accepted. Input accepts one byte per cycle while the four-entry
//   command queue has room; the back end emits one result per cycle while the
//   receiver takes them, so a source byte that expands to three results holds the
//   back end for each of them, while bytes held in an escape cost none.
//   A stalled receiver holds the output register; the queue fills and then
//   in_ch.ready drops. Reset clears the escape state, counts and queue and
//   restores plus_as_space=0, max_out_bytes=65535; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    pcd_in_if.sink           in_ch,
    pcd_out_if.source        out_ch
);
    import pcd_pkg::*;

    logic        plus_reg;
    logic [15:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_reg <= 1'b0;
            max_reg  <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLUS_AS_SPACE: plus_reg <= cfg_wdata[0];
                REG_MAX_OUT_BYTES: max_reg  <= cfg_wdata;
                default:           max_reg  <= max_reg;
            endcase
        end
    end

    cmd_t push_cmd;
    cmd_t head;
    logic push, full, pop, empty, accept;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;

    pcd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_ch.in_byte),
        .in_last       (in_ch.in_last),
        .plus_as_space (plus_reg),
        .cmd           (push_cmd),
        .push          (push)
    );

    pcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    pcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .max_out_bytes (max_reg),
        .out_ch        (out_ch)
    );

endmodule

`default_nettype wire
